@@ rtl/frae_pkg.sv @@
package frae_pkg;

  typedef enum logic [3:0] {
    OP_ADDR = 4'd0,
    OP_ADDI = 4'd1,
    OP_MULR = 4'd2,
    OP_MULI = 4'd3,
    OP_BANR = 4'd4,
    OP_BANI = 4'd5,
    OP_BORR = 4'd6,
    OP_BORI = 4'd7,
    OP_SETR = 4'd8,
    OP_SETI = 4'd9,
    OP_GTIR = 4'd10,
    OP_GTRI = 4'd11,
    OP_GTRR = 4'd12,
    OP_EQIR = 4'd13,
    OP_EQRI = 4'd14,
    OP_EQRR = 4'd15
  } op_e;

  localparam int unsigned CodeWidth    = 4;
  localparam int unsigned OperandWidth = 32;
  localparam int unsigned IndexWidth   = 2;
  localparam int unsigned NumRegs      = 4;
  localparam int unsigned OutWidth     = 32;
  localparam int unsigned MapWidth     = 64;

  localparam logic [MapWidth-1:0] MapReset = 64'hFEDC_BA98_7654_3210;

  // one decoded instruction as it waits between front and back
  typedef struct packed {
    op_e                          op;
    logic                         a_is_reg;
    logic                         b_is_reg;
    logic                         bad;
    logic [OperandWidth-1:0]      operand_a;
    logic [OperandWidth-1:0]      operand_b;
    logic [IndexWidth-1:0]        dest;
  } instr_t;

  function automatic logic op_a_is_reg(op_e op);
    return !(op inside {OP_SETI, OP_GTIR, OP_EQIR});
  endfunction

  // setr and seti ignore b, so b is never an index for them
  function automatic logic op_b_is_reg(op_e op);
    return op inside {OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_GTIR, OP_GTRR, OP_EQIR, OP_EQRR};
  endfunction

endpackage

@@ rtl/frae_front.sv @@
module frae_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [frae_pkg::MapWidth-1:0]          cfg_wdata_i,
  input  logic [frae_pkg::CodeWidth-1:0]         code_i,
  input  logic [frae_pkg::OperandWidth-1:0]      operand_a_i,
  input  logic [frae_pkg::OperandWidth-1:0]      operand_b_i,
  input  logic [frae_pkg::IndexWidth-1:0]        dest_index_i,
  output frae_pkg::instr_t                       instr_o
);
  import frae_pkg::*;

  logic [MapWidth-1:0] map_d, map_q;
  op_e                 op;
  logic                a_reg, b_reg;

  assign map_d = cfg_we_i ? cfg_wdata_i : map_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= MapReset;
    end else begin
      map_q <= map_d;
    end
  end

  always_comb begin
    op    = op_e'(map_q[code_i*CodeWidth +: CodeWidth]);
    a_reg = op_a_is_reg(op);
    b_reg = op_b_is_reg(op);
    instr_o.op        = op;
    instr_o.a_is_reg  = a_reg;
    instr_o.b_is_reg  = b_reg;
    // an index above 3 means any upper bit set
    instr_o.bad       = (a_reg && (operand_a_i[OperandWidth-1:IndexWidth] != '0))
                     || (b_reg && (operand_b_i[OperandWidth-1:IndexWidth] != '0));
    instr_o.operand_a = operand_a_i;
    instr_o.operand_b = operand_b_i;
    instr_o.dest      = dest_index_i;
  end

endmodule

@@ rtl/frae_queue.sv @@
module frae_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  frae_pkg::instr_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output frae_pkg::instr_t pop_data_o
);
  import frae_pkg::*;

  localparam int unsigned Depth = 2;

  instr_t      mem_q [Depth];
  logic        wr_ptr_d, wr_ptr_q;
  logic        rd_ptr_d, rd_ptr_q;
  logic [1:0]  count_d, count_q;

  assign full_o     = (count_q == 2'(Depth));
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/frae_back.sv @@
module frae_back #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  frae_pkg::instr_t                 instr_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [frae_pkg::OutWidth-1:0]    reg_zero_o,
  output logic [frae_pkg::OutWidth-1:0]    reg_one_o,
  output logic [frae_pkg::OutWidth-1:0]    reg_two_o,
  output logic [frae_pkg::OutWidth-1:0]    reg_three_o,
  output logic                             bad_index_o
);
  import frae_pkg::*;

  logic [DATA_WIDTH-1:0] rf_q [NumRegs];
  logic [DATA_WIDTH-1:0] rf_d [NumRegs];
  logic [DATA_WIDTH-1:0] va, vb, res;
  logic                  exec;
  logic                  out_valid_d, out_valid_q;
  logic [OutWidth-1:0]   out_reg_q [NumRegs];
  logic                  bad_q;

  function automatic logic [DATA_WIDTH-1:0] rf_read(
    input logic [DATA_WIDTH-1:0] r0, input logic [DATA_WIDTH-1:0] r1,
    input logic [DATA_WIDTH-1:0] r2, input logic [DATA_WIDTH-1:0] r3,
    input logic [IndexWidth-1:0] idx);
    logic [DATA_WIDTH-1:0] v;
    case (idx)
      2'd0:    v = r0;
      2'd1:    v = r1;
      2'd2:    v = r2;
      default: v = r3;
    endcase
    return v;
  endfunction

  // execute when the output slot is free or being drained this cycle
  assign exec  = valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = exec;

  always_comb begin
    va = instr_i.a_is_reg
       ? rf_read(rf_q[0], rf_q[1], rf_q[2], rf_q[3], instr_i.operand_a[IndexWidth-1:0])
       : DATA_WIDTH'(instr_i.operand_a);
    vb = instr_i.b_is_reg
       ? rf_read(rf_q[0], rf_q[1], rf_q[2], rf_q[3], instr_i.operand_b[IndexWidth-1:0])
       : DATA_WIDTH'(instr_i.operand_b);
    case (instr_i.op)
      OP_ADDR, OP_ADDI:          res = va + vb;
      OP_MULR, OP_MULI:          res = va * vb;
      OP_BANR, OP_BANI:          res = va & vb;
      OP_BORR, OP_BORI:          res = va | vb;
      OP_SETR, OP_SETI:          res = va;
      OP_GTIR, OP_GTRI, OP_GTRR: res = DATA_WIDTH'(va > vb);
      default:                   res = DATA_WIDTH'(va == vb);
    endcase
    for (int i = 0; i < NumRegs; i++) begin
      rf_d[i] = rf_q[i];
      if (exec && !instr_i.bad && (instr_i.dest == IndexWidth'(i))) begin
        rf_d[i] = res;
      end
    end
    out_valid_d = exec || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        rf_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      for (int i = 0; i < NumRegs; i++) begin
        rf_q[i] <= rf_d[i];
      end
      out_valid_q <= out_valid_d;
    end
  end

  // output beat is a snapshot of the file right after the step
  always_ff @(posedge clk_i) begin
    if (exec) begin
      for (int i = 0; i < NumRegs; i++) begin
        out_reg_q[i] <= OutWidth'(rf_d[i]);
      end
      bad_q <= instr_i.bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign reg_zero_o  = out_reg_q[0];
  assign reg_one_o   = out_reg_q[1];
  assign reg_two_o   = out_reg_q[2];
  assign reg_three_o = out_reg_q[3];
  assign bad_index_o = bad_q;

endmodule

@@ rtl/four_register_alu_executor_unit.sv @@
// Executes one register-machine instruction per input beat on a file of four
// DATA_WIDTH-bit registers, cleared at reset. The 4-bit code is translated
// through the 64-bit code map (nibble k holds the operation for code k,
// identity after reset) before the instruction is queued. Each output beat
// reports all four registers after the step (low 32 bits) and bad_index,
// which is set with no write when a register operand index exceeds 3.
// Throughput is one instruction per cycle while the output is not stalled;
// the back end reads the register file, runs the alu (one DATA_WIDTH
// multiplier) and writes back as it takes the instruction. A two-entry queue
// between decode and execute plus the output register absorb stalls.
// Write the code map only while no instruction is in flight.
module four_register_alu_executor_unit #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [frae_pkg::MapWidth-1:0]          cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [frae_pkg::CodeWidth-1:0]         code_i,
  input  logic [frae_pkg::OperandWidth-1:0]      operand_a_i,
  input  logic [frae_pkg::OperandWidth-1:0]      operand_b_i,
  input  logic [frae_pkg::IndexWidth-1:0]        dest_index_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [frae_pkg::OutWidth-1:0]          reg_zero_o,
  output logic [frae_pkg::OutWidth-1:0]          reg_one_o,
  output logic [frae_pkg::OutWidth-1:0]          reg_two_o,
  output logic [frae_pkg::OutWidth-1:0]          reg_three_o,
  output logic                                   bad_index_o
);
  import frae_pkg::*;

  instr_t dec_instr, q_instr;
  logic   q_full, q_valid, q_pop, push;

  assign in_ready_o = !q_full;
  assign push       = in_valid_i && !q_full;

  frae_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .code_i       (code_i),
    .operand_a_i  (operand_a_i),
    .operand_b_i  (operand_b_i),
    .dest_index_i (dest_index_i),
    .instr_o      (dec_instr)
  );

  frae_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (dec_instr),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_instr)
  );

  frae_back #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .instr_i     (q_instr),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .reg_zero_o  (reg_zero_o),
    .reg_one_o   (reg_one_o),
    .reg_two_o   (reg_two_o),
    .reg_three_o (reg_three_o),
    .bad_index_o (bad_index_o)
  );

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import frae_pkg::*;

  localparam int unsigned QuietLimit  = 1000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned NumPhases   = 7;
  localparam int unsigned PhaseItems  = 120;

  typedef struct packed {
    logic [OutWidth-1:0] r0;
    logic [OutWidth-1:0] r1;
    logic [OutWidth-1:0] r2;
    logic [OutWidth-1:0] r3;
    logic                bad;
  } reg_snap_t;

  typedef struct packed {
    logic [CodeWidth-1:0]    code;
    logic [OperandWidth-1:0] opa;
    logic [OperandWidth-1:0] opb;
    logic [IndexWidth-1:0]   dest;
    logic                    pinned;
    reg_snap_t               snap;
  } dir_row_t;

  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    cfg_we_i     = 1'b0;
  logic [MapWidth-1:0]     cfg_wdata_i  = '0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_ready_o;
  logic [CodeWidth-1:0]    code_i       = '0;
  logic [OperandWidth-1:0] operand_a_i  = '0;
  logic [OperandWidth-1:0] operand_b_i  = '0;
  logic [IndexWidth-1:0]   dest_index_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i  = 1'b0;
  logic [OutWidth-1:0]     reg_zero_o;
  logic [OutWidth-1:0]     reg_one_o;
  logic [OutWidth-1:0]     reg_two_o;
  logic [OutWidth-1:0]     reg_three_o;
  logic                    bad_index_o;

  // pinned expectation travels with the input beat
  logic      row_pinned = 1'b0;
  reg_snap_t row_snap   = '0;

  logic [31:0]         arch_regs [NumRegs];
  logic [MapWidth-1:0] code_map = MapReset;
  reg_snap_t           reg_snapshots_q [$];

  logic [15:0] op_hits      = '0;
  int          mismatches   = 0;
  int          instrs_in    = 0;
  int          beats_out    = 0;
  int          bad_beats    = 0;
  int          maps_loaded  = 0;
  int          quiet_cycles = 0;
  logic        steady_in    = 1'b0;
  logic        steady_out   = 1'b0;

  // first rows start from cleared registers and the identity map
  dir_row_t directed_rows [24] = '{
    '{OP_SETI, 32'hFFFF_FFFF, 32'h0, 2'd0, 1'b1,
      '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0}},
    '{OP_SETI, 32'h8000_0001, 32'h0, 2'd1, 1'b1,
      '{32'hFFFF_FFFF, 32'h8000_0001, 32'h0, 32'h0, 1'b0}},
    '{OP_ADDR, 32'd0, 32'd1, 2'd2, 1'b1,
      '{32'hFFFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'h0, 1'b0}},
    '{OP_MULR, 32'd0, 32'd0, 2'd3, 1'b1,
      '{32'hFFFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'h1, 1'b0}},
    '{OP_ADDR, 32'd4, 32'd0, 2'd0, 1'b1,
      '{32'hFFFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'h1, 1'b1}},
    '{OP_ADDR, 32'd0, 32'hFFFF_FFFF, 2'd0, 1'b1,
      '{32'hFFFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'h1, 1'b1}},
    // b is ignored by setr, so a huge b is not an error
    '{OP_SETR, 32'd2, 32'hFFFF_FFFF, 2'd0, 1'b1,
      '{32'h8000_0000, 32'h8000_0001, 32'h8000_0000, 32'h1, 1'b0}},
    '{OP_SETI, 32'd0, 32'hDEAD_BEEF, 2'd3, 1'b1,
      '{32'h8000_0000, 32'h8000_0001, 32'h8000_0000, 32'h0, 1'b0}},
    '{OP_SETR, 32'd5, 32'd0, 2'd1, 1'b1,
      '{32'h8000_0000, 32'h8000_0001, 32'h8000_0000, 32'h0, 1'b1}},
    '{OP_EQRI, 32'hFFFF_FFFF, 32'd9, 2'd2, 1'b1,
      '{32'h8000_0000, 32'h8000_0001, 32'h8000_0000, 32'h0, 1'b1}},
    '{OP_GTIR, 32'd7, 32'd4, 2'd1, 1'b1,
      '{32'h8000_0000, 32'h8000_0001, 32'h8000_0000, 32'h0, 1'b1}},
    '{OP_ADDI, 32'd1, 32'hFFFF_FFFF, 2'd3, 1'b0, '0},
    '{OP_MULI, 32'd2, 32'h7FFF_FFFF, 2'd0, 1'b0, '0},
    '{OP_BANR, 32'd1, 32'd2, 2'd1, 1'b0, '0},
    '{OP_BANI, 32'd0, 32'h0F0F_0F0F, 2'd2, 1'b0, '0},
    '{OP_BORR, 32'd1, 32'd3, 2'd0, 1'b0, '0},
    '{OP_BORI, 32'd3, 32'hA5A5_A5A5, 2'd3, 1'b0, '0},
    '{OP_GTIR, 32'hFFFF_FFFF, 32'd0, 2'd1, 1'b0, '0},
    '{OP_GTIR, 32'd0, 32'd1, 2'd2, 1'b0, '0},
    '{OP_GTRI, 32'd0, 32'd0, 2'd0, 1'b0, '0},
    '{OP_GTRR, 32'd2, 32'd3, 2'd1, 1'b0, '0},
    '{OP_EQIR, 32'h8000_0000, 32'd2, 2'd2, 1'b0, '0},
    '{OP_EQRI, 32'd3, 32'd0, 2'd3, 1'b0, '0},
    '{OP_EQRR, 32'd1, 32'd1, 2'd0, 1'b0, '0}
  };

  four_register_alu_executor_unit #(
    .DATA_WIDTH(32)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .code_i      (code_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .dest_index_i(dest_index_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .reg_zero_o  (reg_zero_o),
    .reg_one_o   (reg_one_o),
    .reg_two_o   (reg_two_o),
    .reg_three_o (reg_three_o),
    .bad_index_o (bad_index_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic src_a_is_reg(op_e op);
    case (op)
      OP_SETI, OP_GTIR, OP_EQIR: return 1'b0;
      default:                   return 1'b1;
    endcase
  endfunction

  // setr and seti never look at b
  function automatic logic src_b_is_reg(op_e op);
    case (op)
      OP_ADDR, OP_MULR, OP_BANR, OP_BORR,
      OP_GTIR, OP_GTRR, OP_EQIR, OP_EQRR: return 1'b1;
      default:                            return 1'b0;
    endcase
  endfunction

  function automatic reg_snap_t execute_instr(logic [CodeWidth-1:0] code,
                                              logic [OperandWidth-1:0] opa,
                                              logic [OperandWidth-1:0] opb,
                                              logic [IndexWidth-1:0] dest);
    op_e         op;
    logic        bad;
    logic [31:0] va;
    logic [31:0] vb;
    logic [31:0] res;
    op  = op_e'(code_map[4*code +: 4]);
    bad = 1'b0;
    va  = opa;
    vb  = opb;
    if (src_a_is_reg(op)) begin
      if (opa > 3) bad = 1'b1;
      else va = arch_regs[opa[1:0]];
    end
    if (src_b_is_reg(op)) begin
      if (opb > 3) bad = 1'b1;
      else vb = arch_regs[opb[1:0]];
    end
    case (op)
      OP_ADDR, OP_ADDI:          res = va + vb;
      OP_MULR, OP_MULI:          res = va * vb;
      OP_BANR, OP_BANI:          res = va & vb;
      OP_BORR, OP_BORI:          res = va | vb;
      OP_SETR, OP_SETI:          res = va;
      OP_GTIR, OP_GTRI, OP_GTRR: res = {31'd0, va > vb};
      default:                   res = {31'd0, va == vb};
    endcase
    if (!bad) arch_regs[dest] = res;
    op_hits[op] = 1'b1;
    return '{arch_regs[0], arch_regs[1], arch_regs[2], arch_regs[3], bad};
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [OperandWidth-1:0] pick_operand(logic is_reg);
    if (is_reg) return $urandom_range(0, 3);
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: begin
        case ($urandom_range(0, 4))
          0:       return 32'h0;
          1:       return 32'hFFFF_FFFF;
          2:       return 32'h8000_0000;
          3:       return 32'h7FFF_FFFF;
          default: return 32'h1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic issue_instr(input logic [CodeWidth-1:0] code,
                             input logic [OperandWidth-1:0] opa,
                             input logic [OperandWidth-1:0] opb,
                             input logic [IndexWidth-1:0] dest,
                             input logic pinned,
                             input reg_snap_t snap);
    int gap;
    if ($urandom_range(0, 39) == 0) steady_in = !steady_in;
    gap = steady_in ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    code_i       <= code;
    operand_a_i  <= opa;
    operand_b_i  <= opb;
    dest_index_i <= dest;
    row_pinned   <= pinned;
    row_snap     <= snap;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // map changes only with nothing in flight
  task automatic load_code_map(input logic [MapWidth-1:0] map);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (reg_snapshots_q.size() == 0);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= map;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    code_map     = map;
    maps_loaded++;
  endtask

  initial begin : stimulus
    logic [MapWidth-1:0]     map_plan [NumPhases];
    logic [CodeWidth-1:0]    code;
    logic [OperandWidth-1:0] opa;
    logic [OperandWidth-1:0] opb;
    logic [IndexWidth-1:0]   dest;
    op_e                     op;
    map_plan = '{MapReset, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF,
                 {$urandom, $urandom}, {$urandom, $urandom}, MapReset};
    foreach (arch_regs[i]) arch_regs[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      issue_instr(directed_rows[i].code, directed_rows[i].opa, directed_rows[i].opb,
                  directed_rows[i].dest, directed_rows[i].pinned, directed_rows[i].snap);

    for (int phase = 0; phase < NumPhases; phase++) begin
      if (phase > 0) load_code_map(map_plan[phase]);
      for (int n = 0; n < PhaseItems; n++) begin
        code = 4'($urandom_range(0, 15));
        op   = op_e'(code_map[4*code +: 4]);
        dest = 2'($urandom_range(0, 3));
        // mostly legal operands for the decoded op, some noise
        if ($urandom_range(0, 99) < 85) begin
          opa = pick_operand(src_a_is_reg(op));
          opb = pick_operand(src_b_is_reg(op));
        end else begin
          opa = pick_operand(1'($urandom_range(0, 1)));
          opb = pick_operand(1'($urandom_range(0, 1)));
        end
        issue_instr(code, opa, opb, dest, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (reg_snapshots_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("ran %0d instructions over %0d code map loads, %0d beats checked",
             instrs_in, maps_loaded, beats_out);
    $display("%0d beats flagged a bad register index, %0d of 16 operations executed",
             bad_beats, $countones(op_hits));
    if (mismatches == 0 && reg_snapshots_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin : drain
    int stall;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) steady_out = !steady_out;
      stall = steady_out ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin : scoreboard
    reg_snap_t want;
    reg_snap_t got;
    reg_snap_t predicted;
    if (rst_ni) begin
      // output first: an input beat accepted here cannot come out in the same cycle
      if (out_valid_o && out_ready_i) begin
        got = '{reg_zero_o, reg_one_o, reg_two_o, reg_three_o, bad_index_o};
        beats_out++;
        if (got.bad === 1'b1) bad_beats++;
        if (reg_snapshots_q.size() == 0) begin
          $display("%0t: output beat with nothing expected: %h %h %h %h bad=%b",
                   $time, got.r0, got.r1, got.r2, got.r3, got.bad);
          mismatches++;
        end else begin
          want = reg_snapshots_q.pop_front();
          check_field("reg_zero", want.r0, got.r0);
          check_field("reg_one", want.r1, got.r1);
          check_field("reg_two", want.r2, got.r2);
          check_field("reg_three", want.r3, got.r3);
          check_field("bad_index", {31'd0, want.bad}, {31'd0, got.bad});
        end
      end
      if (in_valid_i && in_ready_o) begin
        predicted = execute_instr(code_i, operand_a_i, operand_b_i, dest_index_i);
        reg_snapshots_q.insert(reg_snapshots_q.size(), row_pinned ? row_snap : predicted);
        instrs_in++;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QuietLimit) begin
      $display("%0t: no beat accepted for %0d cycles", $time, QuietLimit);
      $display("tb: FAIL");
      $finish;
    end
  end

endmodule
